### hw/rtl/vss_pkg.sv
package vss_pkg;

    // Default coordinate width of the viewport request fields.
    localparam int VSS_COORD_BITS = 16;

    // Fixed field widths.
    localparam int REQ_TYPE_W = 2;
    localparam int TGT_W      = 15;
    localparam int FLAG_W     = 4;
    localparam int RECT_W     = 32;
    localparam int XY_OUT_W   = 16;
    localparam int CTR_W      = 18;
    localparam int PACK_W     = 32;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register reset values.
    localparam logic [TGT_W-1:0]  TARGET_W_RST = TGT_W'(1280);
    localparam logic [TGT_W-1:0]  TARGET_H_RST = TGT_W'(720);
    localparam logic [FLAG_W-1:0] FLAGS_RST    = '0;

    // Request codes.
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_VIEWPORT = 2'd0,
        REQ_RECT     = 2'd1,
        REQ_ENABLE   = 2'd2
    } t_req_type;

    // Register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET_W = 2'd0,
        REG_TARGET_H = 2'd1,
        REG_FLAGS    = 2'd2
    } t_reg_idx;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [TGT_W-1:0]  target_width;
        logic [TGT_W-1:0]  target_height;
        logic [FLAG_W-1:0] flag_bits;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [XY_OUT_W-1:0] clipped_x;
        logic [XY_OUT_W-1:0] clipped_y;
        logic [TGT_W-1:0]    clipped_width;
        logic [TGT_W-1:0]    clipped_height;
        logic [CTR_W-1:0]    center_x_twice;
        logic [CTR_W-1:0]    center_y_twice;
        logic [TGT_W-1:0]    clip_left;
        logic [TGT_W-1:0]    clip_top;
        logic [TGT_W-1:0]    clip_right;
        logic [TGT_W-1:0]    clip_bottom;
        logic [PACK_W-1:0]   packed_top_left;
        logic [PACK_W-1:0]   packed_bottom_right;
    } t_result;

endpackage

### hw/rtl/vss_req_if.sv
interface vss_req_if import vss_pkg::*; #(
    parameter int COORD_BITS = VSS_COORD_BITS
);
    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [COORD_BITS-1:0]   vp_x;
    logic [COORD_BITS-1:0]   vp_y;
    logic [COORD_BITS-1:0]   vp_width;
    logic [COORD_BITS-1:0]   vp_height;
    logic signed [RECT_W-1:0] rect_left;
    logic signed [RECT_W-1:0] rect_top;
    logic signed [RECT_W-1:0] rect_right;
    logic signed [RECT_W-1:0] rect_bottom;
    logic                    enable_value;

    modport source (
        output valid, req_type, vp_x, vp_y, vp_width, vp_height,
               rect_left, rect_top, rect_right, rect_bottom, enable_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, vp_x, vp_y, vp_width, vp_height,
               rect_left, rect_top, rect_right, rect_bottom, enable_value,
        output ready
    );
endinterface

### hw/rtl/vss_res_if.sv
interface vss_res_if import vss_pkg::*;;
    logic                valid;
    logic                ready;
    logic [XY_OUT_W-1:0] clipped_x;
    logic [XY_OUT_W-1:0] clipped_y;
    logic [TGT_W-1:0]    clipped_width;
    logic [TGT_W-1:0]    clipped_height;
    logic [CTR_W-1:0]    center_x_twice;
    logic [CTR_W-1:0]    center_y_twice;
    logic [TGT_W-1:0]    clip_left;
    logic [TGT_W-1:0]    clip_top;
    logic [TGT_W-1:0]    clip_right;
    logic [TGT_W-1:0]    clip_bottom;
    logic [PACK_W-1:0]   packed_top_left;
    logic [PACK_W-1:0]   packed_bottom_right;

    modport source (
        output valid, clipped_x, clipped_y, clipped_width, clipped_height,
               center_x_twice, center_y_twice, clip_left, clip_top, clip_right,
               clip_bottom, packed_top_left, packed_bottom_right,
        input  ready
    );

    modport sink (
        input  valid, clipped_x, clipped_y, clipped_width, clipped_height,
               center_x_twice, center_y_twice, clip_left, clip_top, clip_right,
               clip_bottom, packed_top_left, packed_bottom_right,
        output ready
    );
endinterface

### hw/rtl/vss_regs.sv
module vss_regs import vss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 n_wr;
    logic [REG_IDX_W-1:0] n_idx;

    // Registers sit on 4-byte boundaries; the port never waits.
    assign pready = 1'b1;
    assign n_idx  = paddr[APB_ADDR_W-1:2];
    assign n_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_width  <= TARGET_W_RST;
            r_cfg.target_height <= TARGET_H_RST;
            r_cfg.flag_bits     <= FLAGS_RST;
        end else if (n_wr) begin
            case (n_idx)
                REG_TARGET_W: r_cfg.target_width  <= pwdata[TGT_W-1:0];
                REG_TARGET_H: r_cfg.target_height <= pwdata[TGT_W-1:0];
                REG_FLAGS:    r_cfg.flag_bits     <= pwdata[FLAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (n_idx)
            REG_TARGET_W: prdata = APB_DATA_W'(r_cfg.target_width);
            REG_TARGET_H: prdata = APB_DATA_W'(r_cfg.target_height);
            REG_FLAGS:    prdata = APB_DATA_W'(r_cfg.flag_bits);
            default:      prdata = '0;
        endcase
    end

endmodule

### hw/rtl/vss_result.sv
module vss_result import vss_pkg::*; #(
    parameter int COORD_BITS = VSS_COORD_BITS
) (
    input  logic [COORD_BITS-1:0]    i_vp_x,
    input  logic [COORD_BITS-1:0]    i_vp_y,
    input  logic [TGT_W-1:0]         i_vp_w,
    input  logic [TGT_W-1:0]         i_vp_h,
    input  logic signed [RECT_W-1:0] i_rect_left,
    input  logic signed [RECT_W-1:0] i_rect_top,
    input  logic signed [RECT_W-1:0] i_rect_right,
    input  logic signed [RECT_W-1:0] i_rect_bottom,
    input  logic                     i_scissor_on,
    input  t_cfg                     i_cfg,
    output t_result                  o_res
);

    // Signed width that holds both a rectangle edge and the viewport's far edge.
    localparam int SW = (COORD_BITS + 2 > RECT_W + 1) ? COORD_BITS + 2 : RECT_W + 1;
    // Width of 2x + w before it is cut to the output width.
    localparam int CW = ((COORD_BITS + 1 > TGT_W) ? COORD_BITS + 1 : TGT_W) + 1;

    logic signed [SW-1:0] n_vl, n_vt, n_vr, n_vb;
    logic signed [SW-1:0] n_rl, n_rt, n_rr, n_rb;
    logic signed [SW-1:0] n_l, n_t, n_r, n_b;
    logic [TGT_W-1:0]     n_cl, n_ct, n_cr, n_cb;
    logic                 n_empty;
    logic [CW-1:0]        n_ctr_x, n_ctr_y;

    // Clamp a signed edge into [0, limit].
    function automatic logic [TGT_W-1:0] clamp_edge(input logic signed [SW-1:0] v,
                                                    input logic [TGT_W-1:0] limit);
        logic signed [SW-1:0] lim_s;
        lim_s = signed'(SW'(limit));
        if (v < 0) begin
            return '0;
        end else if (v > lim_s) begin
            return limit;
        end else begin
            return v[TGT_W-1:0];
        end
    endfunction

    // Viewport edges, and the rectangle edges sign-extended.
    always_comb begin
        n_vl = signed'(SW'(i_vp_x));
        n_vt = signed'(SW'(i_vp_y));
        n_vr = n_vl + signed'(SW'(i_vp_w));
        n_vb = n_vt + signed'(SW'(i_vp_h));
        n_rl = SW'(i_rect_left);
        n_rt = SW'(i_rect_top);
        n_rr = SW'(i_rect_right);
        n_rb = SW'(i_rect_bottom);
    end

    // Intersect with the rectangle when the scissor is on.
    always_comb begin
        n_l = n_vl;
        n_t = n_vt;
        n_r = n_vr;
        n_b = n_vb;
        if (i_scissor_on) begin
            if (n_rl > n_vl) n_l = n_rl;
            if (n_rt > n_vt) n_t = n_rt;
            if (n_rr < n_vr) n_r = n_rr;
            if (n_rb < n_vb) n_b = n_rb;
        end
    end

    // Clamp to the target and detect an empty scissor.
    always_comb begin
        n_cl    = clamp_edge(n_l, i_cfg.target_width);
        n_cr    = clamp_edge(n_r, i_cfg.target_width);
        n_ct    = clamp_edge(n_t, i_cfg.target_height);
        n_cb    = clamp_edge(n_b, i_cfg.target_height);
        n_empty = (n_cl >= n_cr) || (n_ct >= n_cb);
    end

    // Doubled viewport centre.
    assign n_ctr_x = (CW'(i_vp_x) << 1) + CW'(i_vp_w);
    assign n_ctr_y = (CW'(i_vp_y) << 1) + CW'(i_vp_h);

    // Assemble the result; packed words use the edges before clamping.
    always_comb begin
        o_res.clipped_x           = XY_OUT_W'(i_vp_x);
        o_res.clipped_y           = XY_OUT_W'(i_vp_y);
        o_res.clipped_width       = i_vp_w;
        o_res.clipped_height      = i_vp_h;
        o_res.center_x_twice      = CTR_W'(n_ctr_x);
        o_res.center_y_twice      = CTR_W'(n_ctr_y);
        o_res.clip_left           = n_empty ? '0 : n_cl;
        o_res.clip_top            = n_empty ? '0 : n_ct;
        o_res.clip_right          = n_empty ? '0 : n_cr;
        o_res.clip_bottom         = n_empty ? '0 : n_cb;
        o_res.packed_top_left     = {i_cfg.flag_bits[1], n_t[TGT_W-1:0],
                                     i_cfg.flag_bits[0], n_l[TGT_W-1:0]};
        o_res.packed_bottom_right = {i_cfg.flag_bits[3], n_b[TGT_W-1:0],
                                     i_cfg.flag_bits[2], n_r[TGT_W-1:0]};
    end

endmodule

### hw/rtl/viewport_scissor_setup.sv
// Viewport and scissor raster-state block. Each request on i_req sets the
// viewport, the scissor rectangle or the scissor enable, and produces one
// result on o_res with the stored viewport, its doubled center, the clamped
// scissor and the two packed scissor words, all reflecting the state after
// that request. One request is accepted every clock cycle while the output
// is not stalled. An accepted request enters the input register, then
// updates the state, and its result is then registered in the result
// register. A stalled output holds the pipeline without losing requests.
// Target size and scissor flag bits are written over the APB port at byte
// addresses 0, 4 and 8; the user must write them only while no request is
// in flight, as the block itself does not enforce it.
module viewport_scissor_setup import vss_pkg::*; #(
    parameter int COORD_BITS = VSS_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vss_req_if.sink               i_req,
    vss_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Width of x + w and of min(target, x + w).
    localparam int PW = ((COORD_BITS > TGT_W) ? COORD_BITS : TGT_W) + 1;

    t_cfg cfg;

    // Pipeline control.
    logic r_v1, r_v2, r_v3;
    logic n_en1, n_en2, n_en3;

    // Input register.
    logic [REQ_TYPE_W-1:0]    r_req_type;
    logic [COORD_BITS-1:0]    r_in_x, r_in_y, r_in_w, r_in_h;
    logic signed [RECT_W-1:0] r_in_rl, r_in_rt, r_in_rr, r_in_rb;
    logic                     r_in_en;

    // Raster state.
    logic [COORD_BITS-1:0]    r_vp_x, r_vp_y;
    logic [TGT_W-1:0]         r_vp_w, r_vp_h;
    logic signed [RECT_W-1:0] r_rect_l, r_rect_t, r_rect_r, r_rect_b;
    logic                     r_scissor_on;

    // Viewport clipping.
    logic [PW-1:0]    n_right, n_bottom, n_min_r, n_min_b;
    logic             n_neg;
    logic [TGT_W-1:0] n_vp_w, n_vp_h;

    // Result register.
    t_result n_res;
    t_result r_res;

    vss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Each stage moves when the one after it is free or moving.
    assign n_en3       = !r_v3 || o_res.ready;
    assign n_en2       = !r_v2 || n_en3;
    assign n_en1       = !r_v1 || n_en2;
    assign i_req.ready = n_en1;

    // Clip a new viewport to the target; a negative size zeroes both.
    always_comb begin
        n_right  = PW'(r_in_x) + PW'(r_in_w);
        n_bottom = PW'(r_in_y) + PW'(r_in_h);
        n_min_r  = (n_right < PW'(cfg.target_width)) ? n_right : PW'(cfg.target_width);
        n_min_b  = (n_bottom < PW'(cfg.target_height)) ? n_bottom : PW'(cfg.target_height);
        n_neg    = (n_min_r < PW'(r_in_x)) || (n_min_b < PW'(r_in_y));
        n_vp_w   = n_neg ? '0 : TGT_W'(n_min_r - PW'(r_in_x));
        n_vp_h   = n_neg ? '0 : TGT_W'(n_min_b - PW'(r_in_y));
    end

    // Valid bits and raster state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_vp_x       <= '0;
            r_vp_y       <= '0;
            r_vp_w       <= '0;
            r_vp_h       <= '0;
            r_rect_l     <= '0;
            r_rect_t     <= '0;
            r_rect_r     <= '0;
            r_rect_b     <= '0;
            r_scissor_on <= 1'b0;
        end else begin
            if (n_en1) r_v1 <= i_req.valid;
            if (n_en2) r_v2 <= r_v1;
            if (n_en3) r_v3 <= r_v2;
            if (r_v1 && n_en2) begin
                case (r_req_type)
                    REQ_VIEWPORT: begin
                        r_vp_x <= r_in_x;
                        r_vp_y <= r_in_y;
                        r_vp_w <= n_vp_w;
                        r_vp_h <= n_vp_h;
                    end
                    REQ_RECT: begin
                        r_rect_l <= r_in_rl;
                        r_rect_t <= r_in_rt;
                        r_rect_r <= r_in_rr;
                        r_rect_b <= r_in_rb;
                    end
                    REQ_ENABLE: begin
                        r_scissor_on <= r_in_en;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture an accepted request.
    always_ff @(posedge i_clk) begin
        if (n_en1 && i_req.valid) begin
            r_req_type <= i_req.req_type;
            r_in_x     <= i_req.vp_x;
            r_in_y     <= i_req.vp_y;
            r_in_w     <= i_req.vp_width;
            r_in_h     <= i_req.vp_height;
            r_in_rl    <= i_req.rect_left;
            r_in_rt    <= i_req.rect_top;
            r_in_rr    <= i_req.rect_right;
            r_in_rb    <= i_req.rect_bottom;
            r_in_en    <= i_req.enable_value;
        end
    end

    // Scissor and result fields from the updated state.
    vss_result #(
        .COORD_BITS (COORD_BITS)
    ) u_result (
        .i_vp_x        (r_vp_x),
        .i_vp_y        (r_vp_y),
        .i_vp_w        (r_vp_w),
        .i_vp_h        (r_vp_h),
        .i_rect_left   (r_rect_l),
        .i_rect_top    (r_rect_t),
        .i_rect_right  (r_rect_r),
        .i_rect_bottom (r_rect_b),
        .i_scissor_on  (r_scissor_on),
        .i_cfg         (cfg),
        .o_res         (n_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (n_en3 && r_v2) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid               = r_v3;
    assign o_res.clipped_x           = r_res.clipped_x;
    assign o_res.clipped_y           = r_res.clipped_y;
    assign o_res.clipped_width       = r_res.clipped_width;
    assign o_res.clipped_height      = r_res.clipped_height;
    assign o_res.center_x_twice      = r_res.center_x_twice;
    assign o_res.center_y_twice      = r_res.center_y_twice;
    assign o_res.clip_left           = r_res.clip_left;
    assign o_res.clip_top            = r_res.clip_top;
    assign o_res.clip_right          = r_res.clip_right;
    assign o_res.clip_bottom         = r_res.clip_bottom;
    assign o_res.packed_top_left     = r_res.packed_top_left;
    assign o_res.packed_bottom_right = r_res.packed_bottom_right;

endmodule
